[src/ukvt_pkg.sv]
// shared types and codes for the unsorted key-value table
// no dependencies
package ukvt_pkg;

	localparam int DEPTH_DEF = 512;
	localparam int FUNC_W = 3;
	localparam int POS_W = 10;
	localparam int TOTAL_W = 10;
	localparam int QUEUE_DEPTH = 2;

	// function codes on the func port
	localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_LOOKUP   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DEL_KEY  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_POS  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DEL_EVEN = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DEL_ODD  = 3'd5;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_LOOKUP   = 3'd1,
		OP_DEL_KEY  = 3'd2,
		OP_DEL_POS  = 3'd3,
		OP_DEL_EVEN = 3'd4,
		OP_DEL_ODD  = 3'd5,
		OP_NOP      = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_MISS = 2'd3
	} stat_t;

	typedef struct packed {
		op_t               op;
		logic signed [31:0] key;
		logic [31:0]       value;
		logic [POS_W-1:0]  position;
	} cmd_t;

endpackage

[src/ukvt_front.sv]
// front end: takes command words, decodes the function code, queues them
// depends on ukvt_pkg
module ukvt_front
	import ukvt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [31:0]       key,
	input  logic [31:0]              value,
	input  logic [POS_W-1:0]         position,
	output logic                     cmd_valid,
	output cmd_t                     cmd,
	input  logic                     cmd_pop
);

	cmd_t       slot_q [QUEUE_DEPTH];
	logic       head_q, tail_q;
	logic [1:0] fill_q;
	op_t        op_dec;
	logic       push;

	always_comb begin
		unique case (func)
			FN_INSERT:   op_dec = OP_INSERT;
			FN_LOOKUP:   op_dec = OP_LOOKUP;
			FN_DEL_KEY:  op_dec = OP_DEL_KEY;
			FN_DEL_POS:  op_dec = OP_DEL_POS;
			FN_DEL_EVEN: op_dec = OP_DEL_EVEN;
			FN_DEL_ODD:  op_dec = OP_DEL_ODD;
			default:     op_dec = OP_NOP;
		endcase
	end

	assign busy = (fill_q == 2'(QUEUE_DEPTH));
	assign push = start && !busy;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd = slot_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= '{op: op_dec, key: key, value: value, position: position};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			tail_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) tail_q <= !tail_q;
			if (cmd_pop) head_q <= !head_q;
			fill_q <= fill_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

[src/ukvt_back.sv]
// back end: key and value memories, scan and compaction sequencer, result register
// depends on ukvt_pkg
module ukvt_back
	import ukvt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  cmd_t                cmd,
	output logic                cmd_pop,
	output logic                strobe,
	output logic                found,
	output logic [31:0]         value_out,
	output logic [1:0]          status,
	output logic [TOTAL_W-1:0]  entry_total
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_SCAN    = 4'b0010,
		S_COMPACT = 4'b0100,
		S_DONE    = 4'b1000
	} state_t;

	logic [31:0] key_mem [DEPTH];
	logic [31:0] val_mem [DEPTH];

	state_t        state_q;
	cmd_t          cur_q;
	logic [CW-1:0] count_q, rd_q, wr_q, drop_q, pend_idx_q;
	logic          pend_q, parity_mode_q, found_q;
	stat_t         stat_q;
	logic [31:0]   vout_q;
	logic [31:0]   rd_key, rd_val;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_key, wr_val;
	logic          hit, keep, more;

	assign hit  = pend_q && (rd_key == cur_q.key);
	assign more = (rd_q < count_q);
	// parity pass keeps keys whose low bit differs from the one removed
	assign keep = parity_mode_q ? (rd_key[0] != (cur_q.op == OP_DEL_ODD))
	                            : (pend_idx_q != drop_q);

	always_ff @(posedge clk) begin
		rd_key <= key_mem[rd_q[AW-1:0]];
		rd_val <= val_mem[rd_q[AW-1:0]];
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = wr_q[AW-1:0];
		wr_key = rd_key;
		wr_val = rd_val;
		if (state_q == S_SCAN && !hit && !more && cur_q.op == OP_INSERT &&
		    count_q < CW'(DEPTH)) begin
			wr_en = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_key = cur_q.key;
			wr_val = cur_q.value;
		end else if (state_q == S_COMPACT && pend_q && keep) begin
			wr_en = 1'b1;
		end
	end

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	always_ff @(posedge clk) begin
		if (cmd_pop) cur_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			drop_q <= '0;
			pend_idx_q <= '0;
			pend_q <= 1'b0;
			parity_mode_q <= 1'b0;
			found_q <= 1'b0;
			stat_q <= ST_DONE;
			vout_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						found_q <= 1'b0;
						stat_q <= ST_DONE;
						vout_q <= '0;
						pend_q <= 1'b0;
						rd_q <= '0;
						wr_q <= '0;
						parity_mode_q <= 1'b0;
						unique case (cmd.op)
							OP_INSERT, OP_LOOKUP, OP_DEL_KEY: state_q <= S_SCAN;
							OP_DEL_POS: begin
								if (PW'(cmd.position) < PW'(count_q)) begin
									found_q <= 1'b1;
									rd_q <= CW'(cmd.position);
									wr_q <= CW'(cmd.position);
									drop_q <= CW'(cmd.position);
									state_q <= S_COMPACT;
								end else begin
									stat_q <= ST_MISS;
									state_q <= S_DONE;
								end
							end
							OP_DEL_EVEN, OP_DEL_ODD: begin
								parity_mode_q <= 1'b1;
								state_q <= S_COMPACT;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						pend_q <= 1'b0;
						unique case (cur_q.op)
							OP_INSERT: begin
								stat_q <= ST_DUP;
								state_q <= S_DONE;
							end
							OP_LOOKUP: begin
								found_q <= 1'b1;
								vout_q <= rd_val;
								state_q <= S_DONE;
							end
							default: begin
								// delete by key: close the gap from the match onward
								found_q <= 1'b1;
								rd_q <= pend_idx_q;
								wr_q <= pend_idx_q;
								drop_q <= pend_idx_q;
								state_q <= S_COMPACT;
							end
						endcase
					end else if (more) begin
						pend_q <= 1'b1;
						pend_idx_q <= rd_q;
						rd_q <= rd_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
						state_q <= S_DONE;
						if (cur_q.op == OP_INSERT) begin
							if (count_q < CW'(DEPTH)) count_q <= count_q + 1'b1;
							else stat_q <= ST_FULL;
						end else begin
							stat_q <= ST_MISS;
						end
					end
				end
				S_COMPACT: begin
					if (pend_q && keep) wr_q <= wr_q + 1'b1;
					if (more) begin
						pend_q <= 1'b1;
						pend_idx_q <= rd_q;
						rd_q <= rd_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (!pend_q && !more) begin
						count_q <= wr_q;
						if (parity_mode_q) found_q <= (wr_q != count_q);
						state_q <= S_DONE;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe = (state_q == S_DONE);
	assign found = found_q;
	assign value_out = vout_q;
	assign status = stat_q;
	assign entry_total = TOTAL_W'(count_q);

endmodule

[src/unsorted_key_value_table.sv]
// A key-value table of up to DEPTH entries kept packed and unsorted. A scan walks
// the key memory one read per cycle, and a delete then compacts the tail at one move
// per cycle. Commands wait in a two-word queue; busy rises when it is full. Each result
// shows for one cycle with strobe high and cannot be held off, so the receiver must
// take it then.
// top level: front-end queue and back-end sequencer, depends on ukvt_pkg
module unsorted_key_value_table
	import ukvt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [FUNC_W-1:0]   func,
	input  logic signed [31:0]  key,
	input  logic [31:0]         value,
	input  logic [POS_W-1:0]    position,
	output logic                strobe,
	output logic                found,
	output logic [31:0]         value_out,
	output logic [1:0]          status,
	output logic [TOTAL_W-1:0]  entry_total
);

	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	ukvt_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.key(key), .value(value), .position(position),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	ukvt_back #(.DEPTH(DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_pop(cmd_pop), .strobe(strobe), .found(found), .value_out(value_out),
		.status(status), .entry_total(entry_total)
	);

endmodule

[src/ukvt_checker.sv]
// port-level checks for the key-value table, bound to the top level
// depends on ukvt_pkg
module ukvt_checker
	import ukvt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        strobe,
	input logic        found,
	input logic [31:0] value_out,
	input logic [1:0]  status
);

	a_gap: assert property (@(posedge clk) disable iff (!arst_n) strobe |=> !strobe)
		else $error("results on consecutive cycles");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && found |-> status == ST_DONE)
		else $error("found with error status");
	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && value_out != 32'd0 |-> found)
		else $error("value without a hit");
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_MISS || status == ST_DUP || status == ST_FULL) |-> !found)
		else $error("error status with found");

endmodule

bind unsorted_key_value_table ukvt_checker u_chk (.*);

[test/tb.sv]
// testbench for unsorted_key_value_table: drives commands, predicts each result word
// with a behavioral table and checks strobed results in order; depends on ukvt_pkg
`timescale 1ns / 1ps

class table_scoreboard;
	typedef struct {
		logic        found;
		logic [31:0] value_out;
		logic [1:0]  status;
		logic [9:0]  entry_total;
	} result_t;

	result_t pending[$];
	logic [31:0] keys[$];
	logic [31:0] vals[$];
	int depth;
	int errors;

	function new(int d);
		depth = d;
		errors = 0;
	endfunction

	function int find_key(logic [31:0] k);
		foreach (keys[i])
			if (keys[i] == k)
				return i;
		return -1;
	endfunction

	function bit drop_parity(bit par);
		logic [31:0] nk[$];
		logic [31:0] nv[$];
		bit gone;
		gone = 0;
		foreach (keys[i]) begin
			if (keys[i][0] != par) begin
				nk.push_back(keys[i]);
				nv.push_back(vals[i]);
			end else
				gone = 1;
		end
		keys = nk;
		vals = nv;
		return gone;
	endfunction

	// note an accepted command word and queue its expected result
	function void note_command(logic [2:0] fn, logic [31:0] k, logic [31:0] v,
			logic [9:0] pos);
		result_t r;
		int w;
		r.found = 0;
		r.value_out = 0;
		r.status = ukvt_pkg::ST_DONE;
		w = find_key(k);
		case (fn)
			ukvt_pkg::FN_INSERT: begin
				if (w >= 0)
					r.status = ukvt_pkg::ST_DUP;
				else if (keys.size() >= depth)
					r.status = ukvt_pkg::ST_FULL;
				else begin
					keys.push_back(k);
					vals.push_back(v);
				end
			end
			ukvt_pkg::FN_LOOKUP: begin
				if (w >= 0) begin
					r.found = 1;
					r.value_out = vals[w];
				end else
					r.status = ukvt_pkg::ST_MISS;
			end
			ukvt_pkg::FN_DEL_KEY: begin
				if (w >= 0) begin
					r.found = 1;
					keys.delete(w);
					vals.delete(w);
				end else
					r.status = ukvt_pkg::ST_MISS;
			end
			ukvt_pkg::FN_DEL_POS: begin
				if (pos < keys.size()) begin
					r.found = 1;
					keys.delete(pos);
					vals.delete(pos);
				end else
					r.status = ukvt_pkg::ST_MISS;
			end
			ukvt_pkg::FN_DEL_EVEN: r.found = drop_parity(0);
			ukvt_pkg::FN_DEL_ODD:  r.found = drop_parity(1);
			default: ;
		endcase
		r.entry_total = 10'(keys.size());
		pending.push_back(r);
	endfunction

	function void check_result(logic f, logic [31:0] vo, logic [1:0] st, logic [9:0] tot);
		result_t e;
		if (pending.size() == 0) begin
			$error("result word with no command pending");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (f !== e.found) begin
			$error("found: expected %0d actual %0d", e.found, f);
			errors++;
		end
		if (vo !== e.value_out) begin
			$error("value_out: expected %h actual %h", e.value_out, vo);
			errors++;
		end
		if (st !== e.status) begin
			$error("status: expected %0d actual %0d", e.status, st);
			errors++;
		end
		if (tot !== e.entry_total) begin
			$error("entry_total: expected %0d actual %0d", e.entry_total, tot);
			errors++;
		end
	endfunction
endclass

module tb;
	import ukvt_pkg::*;

	localparam int TBL_DEPTH = 512;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [FUNC_W-1:0] func = FN_INSERT;
	logic signed [31:0] key = 0;
	logic [31:0] value = 0;
	logic [POS_W-1:0] position = 0;
	logic strobe;
	logic found;
	logic [31:0] value_out;
	logic [1:0] status;
	logic [TOTAL_W-1:0] entry_total;

	int idle_pct = 0;
	table_scoreboard sb = new(TBL_DEPTH);

	unsorted_key_value_table #(.DEPTH(TBL_DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.key(key), .value(value), .position(position), .strobe(strobe),
		.found(found), .value_out(value_out), .status(status),
		.entry_total(entry_total)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk)
		if (arst_n && strobe)
			sb.check_result(found, value_out, status, entry_total);

	// offer one command word and hold it until accepted; start stays up for the next
	task automatic send(logic [2:0] fn, logic [31:0] k, logic [31:0] v, logic [9:0] p);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		func <= fn;
		key <= k;
		value <= v;
		position <= p;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(fn, k, v, p);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// mostly keys from a small pool so lookups and deletes hit
	function automatic logic [31:0] pick_key();
		case ($urandom_range(9))
			0: return $urandom;
			1: return {1'($urandom_range(1)), 31'($urandom_range(3))};
			2: return 32'h7fffffff - $urandom_range(3);
			default: return $urandom_range(60) - 30;
		endcase
	endfunction

	task automatic random_burst(int n, int fill);
		logic [2:0] fn;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < fill) fn = FN_INSERT;
			else if (r < fill + 15) fn = FN_LOOKUP;
			else if (r < fill + 27) fn = FN_DEL_KEY;
			else if (r < fill + 37) fn = FN_DEL_POS;
			else if (r < fill + 40) fn = FN_DEL_EVEN;
			else if (r < fill + 43) fn = FN_DEL_ODD;
			else fn = 3'($urandom_range(7));
			send(fn, pick_key(), $urandom,
				($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(
					sb.keys.size() + 1)));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, every operation, special cases
		send(FN_LOOKUP, 32'h5, 0, 0);
		send(FN_DEL_POS, 0, 0, 0);
		send(FN_INSERT, 32'h80000000, 32'hffffffff, 10'h3ff);
		send(FN_INSERT, 32'h7fffffff, 32'h0, 0);
		send(FN_INSERT, 32'hffffffff, 32'haaaaaaaa, 0);
		send(FN_INSERT, 32'h2, 32'h55555555, 0);
		send(FN_INSERT, 32'h80000000, 32'h1, 0);
		send(FN_LOOKUP, 32'h80000000, 0, 0);
		send(FN_LOOKUP, 32'hffffffff, 0, 0);
		send(FN_LOOKUP, 32'h3, 0, 0);
		send(FN_DEL_KEY, 32'h7fffffff, 0, 0);
		send(FN_DEL_KEY, 32'h7fffffff, 0, 0);
		send(3'd6, 32'hffffffff, 32'hffffffff, 10'h3ff);
		send(3'd7, 0, 0, 0);
		send(FN_DEL_POS, 0, 0, 10'h3ff);
		send(FN_DEL_ODD, 0, 0, 0);
		send(FN_DEL_ODD, 0, 0, 0);
		send(FN_DEL_EVEN, 0, 0, 0);
		send(FN_DEL_EVEN, 0, 0, 0);
		send(FN_INSERT, 32'h9, 32'h9, 0);
		send(FN_DEL_POS, 0, 0, 0);
		drain();
		// fill to capacity and push one more to hit the full case
		for (int i = 0; i < TBL_DEPTH; i++)
			send(FN_INSERT, i * 3 - 700, $urandom, 0);
		send(FN_INSERT, 32'h12345, 1, 0);
		send(FN_DEL_POS, 0, 0, 10'(TBL_DEPTH - 1));
		send(FN_DEL_KEY, -700, 0, 0);
		send(FN_DEL_ODD, 0, 0, 0);
		send(FN_DEL_EVEN, 0, 0, 0);
		drain();
		idle_pct = 0;
		random_burst(11, 45);
		idle_pct = 58;
		random_burst(11, 40);
		drain();
		idle_pct = 0;
		random_burst(11, 30);
		idle_pct = 26;
		random_burst(11, 40);
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("unsorted_key_value_table verification clean");
		else
			$display("unsorted_key_value_table verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("unsorted_key_value_table verification failed");
		$finish;
	end
endmodule

[files.f]
src/ukvt_pkg.sv
src/ukvt_front.sv
src/ukvt_back.sv
src/unsorted_key_value_table.sv
src/ukvt_checker.sv
test/tb.sv
